/* hw/rtl/arp_resolver_cache_macros.svh */
// ----------------------------------------------------------------------------
// arp_resolver_cache_macros: assertion helpers
// Concurrent checks that drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ARP_RESOLVER_CACHE_MACROS_SVH
`define ARP_RESOLVER_CACHE_MACROS_SVH
`ifndef SYNTH
`define ARC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("arc check failed");
`define ARC_NEVER(lbl, clk, rst, expr) `ARC_ASSERT(lbl, clk, rst, !(expr))
`else
`define ARC_ASSERT(lbl, clk, rst, prop)
`define ARC_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* hw/rtl/arc_pkg.sv */
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants
// Codes, widths and sequencer states of the ARP resolver cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arc_pkg;

  localparam int MAC_W       = 48;
  localparam int IP_W        = 32;
  localparam int MS_W        = 16;
  localparam int CLK_W       = 48;
  localparam int MAX_RESULTS = 16;
  localparam int RCNT_W      = 5;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_RECV = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] CLASS_ARP  = 2'd0;
  localparam logic [1:0] CLASS_IPV4 = 2'd1;

  localparam logic [1:0] RES_REQUEST = 2'd0;
  localparam logic [1:0] RES_REPLY   = 2'd1;
  localparam logic [1:0] RES_FRAME   = 2'd2;
  localparam logic [1:0] RES_DELIVER = 2'd3;

  localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [1:0] CFG_LIFETIME = 2'd2;
  localparam logic [1:0] CFG_RETRY    = 2'd3;

  localparam logic [MAC_W-1:0] BCAST_MAC    = {MAC_W{1'b1}};
  localparam logic [MS_W-1:0]  LIFETIME_RST = 16'd30000;
  localparam logic [MS_W-1:0]  RETRY_RST    = 16'd5000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MAP_RD,
    S_MAP_CHK,
    S_MAP_WR,
    S_WAIT_RD,
    S_WAIT_CHK,
    S_WAIT_END,
    S_REPLY,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/arc_item_if.sv */
// ----------------------------------------------------------------------------
// arc_item_if: input item channel
// Send, receive and tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arc_item_if #(
  parameter int TAG_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [31:0]              hop_ip;
  logic [TAG_BITS-1:0]      payload_tag;
  logic [47:0]              dst_mac;
  logic [1:0]               frame_class;
  logic                     parse_ok;
  logic                     arp_is_request;
  logic [47:0]              sender_mac;
  logic [31:0]              sender_ip;
  logic [31:0]              target_ip;
  logic [15:0]              elapsed_ms;

  modport source (output valid, kind, hop_ip, payload_tag, dst_mac, frame_class,
                  parse_ok, arp_is_request, sender_mac, sender_ip, target_ip, elapsed_ms,
                  input ready);
  modport sink (input valid, kind, hop_ip, payload_tag, dst_mac, frame_class,
                parse_ok, arp_is_request, sender_mac, sender_ip, target_ip, elapsed_ms,
                output ready);
endinterface

/* hw/rtl/arc_result_if.sv */
// ----------------------------------------------------------------------------
// arc_result_if: result item channel
// Frames and deliveries out, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arc_result_if #(
  parameter int TAG_BITS = 8
);
  logic                valid;
  logic                ready;
  logic [1:0]          result_kind;
  logic [47:0]         out_dst_mac;
  logic [31:0]         out_target_ip;
  logic [TAG_BITS-1:0] out_tag;
  logic                last;

  modport source (output valid, result_kind, out_dst_mac, out_target_ip, out_tag, last,
                  input ready);
  modport sink (input valid, result_kind, out_dst_mac, out_target_ip, out_tag, last,
                output ready);
endinterface

/* hw/rtl/arc_cfg_if.sv */
// ----------------------------------------------------------------------------
// arc_cfg_if: configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/arc_ram.sv */
// ----------------------------------------------------------------------------
// arc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/arp_resolver_cache.sv */
// ----------------------------------------------------------------------------
// arp_resolver_cache: ARP address resolution for one Ethernet interface
// Learned IP-to-MAC table, parked datagrams and request retry in one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   item   : send (kind 0), received frame (kind 1) or tick (kind 2) items.
//   result : ARP request/reply, IPv4 frame out or delivery; last marks the
//            final result of an item. An item may give no result at all.
//   cfg    : register writes (0 own MAC, 1 own IP, 2 lifetime, 3 retry),
//            always ready, to be written only while the block is idle.
// Scan: the sequencer walks the mapping table and then the parked table,
//   each entry through a read state and a check state, with one registered
//   RAM read and one shared stamp-plus-interval compare. item.ready returns
//   when the item is finished; a scan that stops at a match ends early, and
//   a frame that is dropped or delivered goes from start straight to done.
//   One item at a time.
// Results pass through a one-deep hold register and the output register;
//   a stalled receiver holds the sequencer at its next result.
// Reset: clears the clock, all valid bits and the registers to their defaults;
//   table contents are left alone, no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arp_resolver_cache_macros.svh"

module arp_resolver_cache #(
  parameter int MAP_ENTRIES  = 32,
  parameter int WAIT_ENTRIES = 16,
  parameter int TAG_BITS     = 8
) (
  input logic       clk,
  input logic       rst,
  arc_item_if.sink  item,
  arc_result_if.source result,
  arc_cfg_if.sink   cfg
);

  localparam int MAP_AW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int WAIT_AW = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
  localparam int CNT_W   = (MAP_AW > WAIT_AW) ? MAP_AW : WAIT_AW;
  localparam int MAP_DW  = arc_pkg::IP_W + arc_pkg::MAC_W + arc_pkg::CLK_W;
  localparam int WAIT_DW = arc_pkg::IP_W + TAG_BITS + arc_pkg::CLK_W;

  // configuration
  logic [arc_pkg::MAC_W-1:0] own_mac;
  logic [arc_pkg::IP_W-1:0]  own_ip;
  logic [arc_pkg::MS_W-1:0]  lifetime;
  logic [arc_pkg::MS_W-1:0]  retry;

  // latched item
  logic [1:0]                k_kind;
  logic [arc_pkg::IP_W-1:0]  k_nhip;
  logic [TAG_BITS-1:0]       k_tag;
  logic [arc_pkg::MAC_W-1:0] k_dst;
  logic [1:0]                k_cls;
  logic                      k_ok;
  logic                      k_req;
  logic [arc_pkg::MAC_W-1:0] k_smac;
  logic [arc_pkg::IP_W-1:0]  k_sip;
  logic [arc_pkg::IP_W-1:0]  k_tip;
  logic [arc_pkg::MS_W-1:0]  k_elapsed;

  arc_pkg::state_t state, state_next;
  logic [CNT_W-1:0]           idx;
  logic [CNT_W-1:0]           free_idx;
  logic                       free_found;
  logic [arc_pkg::RCNT_W-1:0] res_cnt;
  logic [arc_pkg::CLK_W-1:0]  clock_ms;
  logic [MAP_ENTRIES-1:0]     map_valid;
  logic [WAIT_ENTRIES-1:0]    wait_valid;

  // hold register for the newest result, not yet known to be last
  logic                      pend_valid;
  logic [1:0]                pend_kind;
  logic [arc_pkg::MAC_W-1:0] pend_mac;
  logic [arc_pkg::IP_W-1:0]  pend_ip;
  logic [TAG_BITS-1:0]       pend_tag;

  logic                      out_valid;
  logic [1:0]                out_kind;
  logic [arc_pkg::MAC_W-1:0] out_mac;
  logic [arc_pkg::IP_W-1:0]  out_ip;
  logic [TAG_BITS-1:0]       out_tagr;
  logic                      out_last;

  // RAM ports
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [MAP_DW-1:0]  map_wdata;
  logic [MAP_DW-1:0]  map_rdata;
  logic               wait_we;
  logic [WAIT_AW-1:0] wait_waddr;
  logic [WAIT_DW-1:0] wait_wdata;
  logic [WAIT_DW-1:0] wait_rdata;

  logic [arc_pkg::IP_W-1:0]  m_ip;
  logic [arc_pkg::MAC_W-1:0] m_mac;
  logic [arc_pkg::CLK_W-1:0] m_stamp;
  logic [arc_pkg::IP_W-1:0]  w_ip;
  logic [TAG_BITS-1:0]       w_tag;
  logic [arc_pkg::CLK_W-1:0] w_stamp;

  logic                      m_vld, w_vld, m_match, w_match;
  logic                      map_end, wait_end;
  logic [arc_pkg::IP_W-1:0]  key_ip;
  logic [arc_pkg::CLK_W-1:0] age_stamp;
  logic [arc_pkg::MS_W-1:0]  age_span;
  logic [arc_pkg::CLK_W:0]   age_sum;
  logic                      aged;
  logic [arc_pkg::CLK_W:0]   clk_sum;
  logic                      for_us, out_free, can_emit, go;

  // actions
  logic                      want_emit;
  logic [1:0]                new_kind;
  logic [arc_pkg::MAC_W-1:0] new_mac;
  logic [arc_pkg::IP_W-1:0]  new_ip;
  logic [TAG_BITS-1:0]       new_tag;
  logic                      map_wr, map_set, map_clr, wait_wr, wait_set, wait_clr;
  logic                      use_free, note_free;

  arc_ram #(.WIDTH(MAP_DW), .DEPTH(MAP_ENTRIES)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (idx[MAP_AW-1:0]),
    .rdata (map_rdata)
  );

  arc_ram #(.WIDTH(WAIT_DW), .DEPTH(WAIT_ENTRIES)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_waddr),
    .wdata (wait_wdata),
    .raddr (idx[WAIT_AW-1:0]),
    .rdata (wait_rdata)
  );

  assign {m_ip, m_mac, m_stamp}  = map_rdata;
  assign {w_ip, w_tag, w_stamp}  = wait_rdata;
  assign m_vld    = map_valid[idx[MAP_AW-1:0]];
  assign w_vld    = wait_valid[idx[WAIT_AW-1:0]];
  assign key_ip   = (k_kind == arc_pkg::KIND_RECV) ? k_sip : k_nhip;
  assign m_match  = m_vld && (m_ip == key_ip);
  assign w_match  = w_vld && (w_ip == key_ip);
  assign map_end  = (idx == CNT_W'(MAP_ENTRIES - 1));
  assign wait_end = (idx == CNT_W'(WAIT_ENTRIES - 1));
  assign for_us   = (k_dst == own_mac) || (k_dst == arc_pkg::BCAST_MAC);

  // shared age unit: stamp + interval < clock, without overflow
  assign age_stamp = (state == arc_pkg::S_MAP_CHK) ? m_stamp : w_stamp;
  assign age_span  = (state == arc_pkg::S_MAP_CHK) ? lifetime : retry;
  assign age_sum   = {1'b0, age_stamp} + (arc_pkg::CLK_W + 1)'(age_span);
  assign aged      = age_sum < {1'b0, clock_ms};

  assign clk_sum   = {1'b0, clock_ms} + (arc_pkg::CLK_W + 1)'(k_elapsed);

  assign out_free  = !out_valid || result.ready;
  assign can_emit  = !pend_valid || out_free;
  assign go        = !(want_emit && !can_emit);

  assign item.ready = (state == arc_pkg::S_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid         = out_valid;
  assign result.result_kind   = out_kind;
  assign result.out_dst_mac   = out_mac;
  assign result.out_target_ip = out_ip;
  assign result.out_tag       = out_tagr;
  assign result.last          = out_last;

  // per-state actions
  always_comb begin
    want_emit = 1'b0;
    new_kind  = arc_pkg::RES_REQUEST;
    new_mac   = arc_pkg::BCAST_MAC;
    new_ip    = k_nhip;
    new_tag   = '0;
    map_wr    = 1'b0;
    map_set   = 1'b0;
    map_clr   = 1'b0;
    wait_wr   = 1'b0;
    wait_set  = 1'b0;
    wait_clr  = 1'b0;
    use_free  = 1'b0;
    note_free = 1'b0;
    map_wdata  = {k_sip, k_smac, clock_ms};
    wait_wdata = {k_nhip, k_tag, clock_ms};
    unique case (state)
      arc_pkg::S_START: begin
        if (k_kind == arc_pkg::KIND_RECV && for_us && k_ok && k_cls == arc_pkg::CLASS_IPV4) begin
          want_emit = 1'b1;
          new_kind  = arc_pkg::RES_DELIVER;
          new_mac   = '0;
          new_ip    = '0;
          new_tag   = k_tag;
        end
      end
      arc_pkg::S_MAP_CHK: begin
        case (k_kind)
          arc_pkg::KIND_SEND: begin
            if (m_match) begin
              want_emit = 1'b1;
              new_kind  = arc_pkg::RES_FRAME;
              new_mac   = m_mac;
              new_ip    = '0;
              new_tag   = k_tag;
            end
          end
          arc_pkg::KIND_RECV: begin
            map_wr    = m_match;
            note_free = !m_vld;
          end
          default: begin
            map_clr = m_vld && aged;
          end
        endcase
      end
      arc_pkg::S_MAP_WR: begin
        map_wr   = free_found;
        map_set  = free_found;
        use_free = 1'b1;
      end
      arc_pkg::S_WAIT_CHK: begin
        case (k_kind)
          arc_pkg::KIND_SEND: begin
            note_free  = !w_vld;
            wait_wdata = {w_ip, w_tag, clock_ms};
            if (w_match && aged) begin
              want_emit = 1'b1;
              wait_wr   = 1'b1;
            end
          end
          arc_pkg::KIND_RECV: begin
            if (w_match) begin
              want_emit = 1'b1;
              wait_clr  = 1'b1;
              new_kind  = arc_pkg::RES_FRAME;
              new_mac   = k_smac;
              new_ip    = '0;
              new_tag   = w_tag;
            end
          end
          default: begin
            wait_wdata = {w_ip, w_tag, clock_ms};
            new_ip     = w_ip;
            if (w_vld && aged && res_cnt < arc_pkg::RCNT_W'(arc_pkg::MAX_RESULTS)) begin
              want_emit = 1'b1;
              wait_wr   = 1'b1;
            end
          end
        endcase
      end
      arc_pkg::S_WAIT_END: begin
        // miss with no parked entry: park if room, broadcast regardless
        want_emit = 1'b1;
        wait_wr   = free_found;
        wait_set  = free_found;
        use_free  = 1'b1;
      end
      arc_pkg::S_REPLY: begin
        if (k_req && k_tip == own_ip) begin
          want_emit = 1'b1;
          new_kind  = arc_pkg::RES_REPLY;
          new_mac   = k_smac;
          new_ip    = k_sip;
        end
      end
      default: begin
      end
    endcase
  end

  assign map_we     = map_wr && go;
  assign map_waddr  = use_free ? free_idx[MAP_AW-1:0] : idx[MAP_AW-1:0];
  assign wait_we    = wait_wr && go;
  assign wait_waddr = use_free ? free_idx[WAIT_AW-1:0] : idx[WAIT_AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      arc_pkg::S_IDLE: begin
        if (item.valid) begin
          state_next = arc_pkg::S_START;
        end
      end
      arc_pkg::S_START: begin
        if (k_kind == arc_pkg::KIND_SEND || k_kind == arc_pkg::KIND_TICK) begin
          state_next = arc_pkg::S_MAP_RD;
        end else if (k_kind == arc_pkg::KIND_RECV && for_us && k_ok &&
                     k_cls == arc_pkg::CLASS_ARP) begin
          state_next = arc_pkg::S_MAP_RD;
        end else begin
          state_next = arc_pkg::S_DONE;
        end
      end
      arc_pkg::S_MAP_RD: state_next = arc_pkg::S_MAP_CHK;
      arc_pkg::S_MAP_CHK: begin
        if (go) begin
          if (k_kind == arc_pkg::KIND_SEND && m_match) begin
            state_next = arc_pkg::S_DONE;
          end else if (k_kind == arc_pkg::KIND_RECV && m_match) begin
            state_next = arc_pkg::S_WAIT_RD;
          end else if (!map_end) begin
            state_next = arc_pkg::S_MAP_RD;
          end else if (k_kind == arc_pkg::KIND_RECV) begin
            state_next = arc_pkg::S_MAP_WR;
          end else begin
            state_next = arc_pkg::S_WAIT_RD;
          end
        end
      end
      arc_pkg::S_MAP_WR: state_next = arc_pkg::S_WAIT_RD;
      arc_pkg::S_WAIT_RD: state_next = arc_pkg::S_WAIT_CHK;
      arc_pkg::S_WAIT_CHK: begin
        if (go) begin
          if (w_match && k_kind == arc_pkg::KIND_SEND) begin
            state_next = arc_pkg::S_DONE;
          end else if (w_match && k_kind == arc_pkg::KIND_RECV) begin
            state_next = arc_pkg::S_REPLY;
          end else if (!wait_end) begin
            state_next = arc_pkg::S_WAIT_RD;
          end else if (k_kind == arc_pkg::KIND_SEND) begin
            state_next = arc_pkg::S_WAIT_END;
          end else if (k_kind == arc_pkg::KIND_RECV) begin
            state_next = arc_pkg::S_REPLY;
          end else begin
            state_next = arc_pkg::S_DONE;
          end
        end
      end
      arc_pkg::S_WAIT_END, arc_pkg::S_REPLY: begin
        if (go) begin
          state_next = arc_pkg::S_DONE;
        end
      end
      arc_pkg::S_DONE: begin
        if (!pend_valid || out_free) begin
          state_next = arc_pkg::S_IDLE;
        end
      end
      default: state_next = arc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= arc_pkg::S_IDLE;
      idx        <= '0;
      free_idx   <= '0;
      free_found <= 1'b0;
      res_cnt    <= '0;
      clock_ms   <= '0;
      map_valid  <= '0;
      wait_valid <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      own_mac    <= '0;
      own_ip     <= '0;
      lifetime   <= arc_pkg::LIFETIME_RST;
      retry      <= arc_pkg::RETRY_RST;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        unique case (cfg.index)
          arc_pkg::CFG_OWN_MAC:  own_mac  <= cfg.data;
          arc_pkg::CFG_OWN_IP:   own_ip   <= cfg.data[arc_pkg::IP_W-1:0];
          arc_pkg::CFG_LIFETIME: lifetime <= cfg.data[arc_pkg::MS_W-1:0];
          arc_pkg::CFG_RETRY:    retry    <= cfg.data[arc_pkg::MS_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == arc_pkg::S_IDLE && item.valid) begin
        res_cnt <= '0;
      end

      if (state == arc_pkg::S_START && k_kind == arc_pkg::KIND_TICK) begin
        clock_ms <= clk_sum[arc_pkg::CLK_W] ? {arc_pkg::CLK_W{1'b1}}
                                            : clk_sum[arc_pkg::CLK_W-1:0];
      end

      // scan counter and lowest free slot
      if ((state == arc_pkg::S_MAP_CHK && state_next == arc_pkg::S_MAP_RD) ||
          (state == arc_pkg::S_WAIT_CHK && state_next == arc_pkg::S_WAIT_RD)) begin
        idx <= idx + CNT_W'(1);
      end else if (state_next == arc_pkg::S_MAP_RD || state_next == arc_pkg::S_WAIT_RD) begin
        idx        <= '0;
        free_found <= 1'b0;
      end
      if (note_free && go && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end

      if (go) begin
        if (map_set) begin
          map_valid[free_idx[MAP_AW-1:0]] <= 1'b1;
        end
        if (map_clr) begin
          map_valid[idx[MAP_AW-1:0]] <= 1'b0;
        end
        if (wait_set) begin
          wait_valid[free_idx[WAIT_AW-1:0]] <= 1'b1;
        end
        if (wait_clr) begin
          wait_valid[idx[WAIT_AW-1:0]] <= 1'b0;
        end
      end

      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (want_emit && go) begin
        res_cnt    <= res_cnt + arc_pkg::RCNT_W'(1);
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_last  <= 1'b0;
        end
      end else if (state == arc_pkg::S_DONE && pend_valid && out_free) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
        out_last   <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == arc_pkg::S_IDLE && item.valid) begin
      k_kind    <= item.kind;
      k_nhip    <= item.hop_ip;
      k_tag     <= item.payload_tag;
      k_dst     <= item.dst_mac;
      k_cls     <= item.frame_class;
      k_ok      <= item.parse_ok;
      k_req     <= item.arp_is_request;
      k_smac    <= item.sender_mac;
      k_sip     <= item.sender_ip;
      k_tip     <= item.target_ip;
      k_elapsed <= item.elapsed_ms;
    end
    if ((want_emit && go && pend_valid) ||
        (!(want_emit && go) && state == arc_pkg::S_DONE && pend_valid && out_free)) begin
      out_kind <= pend_kind;
      out_mac  <= pend_mac;
      out_ip   <= pend_ip;
      out_tagr <= pend_tag;
    end
    if (want_emit && go) begin
      pend_kind <= new_kind;
      pend_mac  <= new_mac;
      pend_ip   <= new_ip;
      pend_tag  <= new_tag;
    end
  end

  `ARC_NEVER(a_idle_empty, clk, rst, state == arc_pkg::S_IDLE && pend_valid)
  `ARC_ASSERT(a_res_limit, clk, rst, res_cnt <= arc_pkg::RCNT_W'(arc_pkg::MAX_RESULTS))
  `ARC_ASSERT(a_clock_mono, clk, rst, !rst |=> clock_ms >= $past(clock_ms))

endmodule
